>>> rtl/jhbd_pkg.sv
// jhbd_pkg: shared widths, codes, structs and helpers for the jpeg huffman bit decoder
// depends on nothing; imported by every rtl module of the block
package jhbd_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned IDX_W  = 8;

  localparam int unsigned DC_ENTRIES_DEF   = 16;
  localparam int unsigned AC_ENTRIES_DEF   = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 16;

  localparam logic [SYM_W-1:0] NIBBLE_MASK = 8'h0F;
  localparam logic [SYM_W-1:0] DC_CAT_MAX  = 8'd16;
  localparam logic [LEN_W-1:0] PREFIX_MAX  = LEN_W'(CODE_W);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_BIT  = 1'b1;
  localparam logic TABLE_DC = 1'b0;
  localparam logic TABLE_AC = 1'b1;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
  } cam_load_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [LEN_W-1:0]  plen;
  } cam_key_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } cam_hit_t;

  typedef struct packed {
    logic              valid;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] amp_bits;
    logic [LEN_W-1:0]  amp_len;
    logic              is_dc;
    logic              eob;
    logic              err;
  } dec_res_t;

  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    if (len >= PREFIX_MAX) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return m;
  endfunction

endpackage

>>> rtl/jhbd_cam.sv
// jhbd_cam: code table as a row of compare cells with lowest-index priority select
// depends on jhbd_pkg
module jhbd_cam import jhbd_pkg::*; #(
  parameter int unsigned DEPTH = DC_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cam_load_t load_i,
  input  cam_key_t  key_i,
  output cam_hit_t  res_o
);

  logic [CODE_W-1:0] code_q [DEPTH];
  logic [LEN_W-1:0]  len_q  [DEPTH];
  logic [SYM_W-1:0]  sym_q  [DEPTH];
  logic [DEPTH-1:0]  wr_en;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  first;
  logic [SYM_W-1:0]  sym_sel;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign wr_en[k] = load_i.we && ({1'b0, load_i.index} == (IDX_W+1)'(k));
    assign match[k] = (len_q[k] == key_i.plen) && (code_q[k] == key_i.prefix);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        len_q[k] <= '0;
      end else if (wr_en[k]) begin
        len_q[k] <= load_i.len;
      end
    end

    // stored code keeps only the bits its length covers
    always_ff @(posedge clk_i) begin
      if (wr_en[k]) begin
        code_q[k] <= load_i.code & code_mask(load_i.len);
        sym_q[k]  <= load_i.sym;
      end
    end
  end

  assign first = match & ~(match - DEPTH'(1));

  always_comb begin
    sym_sel = '0;
    for (int k = 0; k < DEPTH; k++) begin
      sym_sel = sym_sel | (sym_q[k] & {SYM_W{first[k]}});
    end
  end

  assign res_o.hit = |match;
  assign res_o.sym = sym_sel;

endmodule

>>> rtl/jhbd_dec.sv
// jhbd_dec: decode state (mode, prefix, amplitude collection) and next-result logic
// depends on jhbd_pkg; takes match results from the two jhbd_cam tables
module jhbd_dec import jhbd_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_i,
  input  logic     commit_i,
  input  logic     bit_i,
  input  cam_hit_t dc_res_i,
  input  cam_hit_t ac_res_i,
  output cam_key_t key_o,
  output dec_res_t res_o
);

  logic              expect_dc_q, expect_dc_d;
  logic              in_amp_q, in_amp_d;
  logic [CODE_W-1:0] prefix_q, prefix_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [CODE_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  total_q, total_d;
  logic [SYM_W-1:0]  held_q, held_d;

  logic [CODE_W-1:0] prefix_n;
  logic [LEN_W-1:0]  plen_n;
  logic [CODE_W-1:0] acc_n;
  logic [LEN_W-1:0]  rem_n;
  logic              hit;
  logic [SYM_W-1:0]  hsym;
  logic [SYM_W-1:0]  nib;
  logic [LEN_W-1:0]  need;
  dec_res_t          res;

  assign prefix_n = {prefix_q[CODE_W-2:0], bit_i};
  assign plen_n   = (plen_q < PREFIX_MAX) ? plen_q + LEN_W'(1) : plen_q;
  assign acc_n    = {acc_q[CODE_W-2:0], bit_i};
  assign rem_n    = (rem_q != '0) ? rem_q - LEN_W'(1) : '0;
  assign hit      = expect_dc_q ? dc_res_i.hit : ac_res_i.hit;
  assign hsym     = expect_dc_q ? dc_res_i.sym : ac_res_i.sym;
  assign nib      = hsym & NIBBLE_MASK;
  assign need     = expect_dc_q ? hsym[LEN_W-1:0] : nib[LEN_W-1:0];

  assign key_o.prefix = prefix_n;
  assign key_o.plen   = plen_n;

  always_comb begin
    expect_dc_d = expect_dc_q;
    in_amp_d    = in_amp_q;
    prefix_d    = prefix_q;
    plen_d      = plen_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    total_d     = total_q;
    held_d      = held_q;
    res         = '0;
    res.is_dc   = expect_dc_q;

    if (in_amp_q) begin
      acc_d = acc_n;
      rem_d = rem_n;
      if (rem_n == '0) begin
        in_amp_d     = 1'b0;
        res.valid    = 1'b1;
        res.symbol   = held_q;
        res.amp_bits = acc_n;
        res.amp_len  = total_q;
        res.eob      = (held_q == '0);
        expect_dc_d  = (held_q == '0);
      end
    end else begin
      prefix_d = prefix_n;
      plen_d   = plen_n;
      if (!hit) begin
        // no match within the longest code length
        if (plen_n >= LEN_W'(MAX_CODE_LEN)) begin
          res.valid   = 1'b1;
          res.err     = 1'b1;
          prefix_d    = '0;
          plen_d      = '0;
          expect_dc_d = 1'b1;
        end
      end else begin
        prefix_d = '0;
        plen_d   = '0;
        if (expect_dc_q && (hsym > DC_CAT_MAX)) begin
          res.valid   = 1'b1;
          res.symbol  = hsym;
          res.err     = 1'b1;
          expect_dc_d = 1'b1;
        end else if (need == '0) begin
          res.valid   = 1'b1;
          res.symbol  = hsym;
          res.eob     = (hsym == '0);
          expect_dc_d = (hsym == '0);
        end else begin
          in_amp_d = 1'b1;
          held_d   = hsym;
          acc_d    = '0;
          rem_d    = need;
          total_d  = need;
        end
      end
    end

    res.valid = res.valid && item_i;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_dc_q <= 1'b1;
      in_amp_q    <= 1'b0;
      prefix_q    <= '0;
      plen_q      <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      total_q     <= '0;
      held_q      <= '0;
    end else if (commit_i) begin
      expect_dc_q <= expect_dc_d;
      in_amp_q    <= in_amp_d;
      prefix_q    <= prefix_d;
      plen_q      <= plen_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      total_q     <= total_d;
      held_q      <= held_d;
    end
  end

endmodule

>>> rtl/jpeg_huffman_bit_decoder_top.sv
// jpeg_huffman_bit_decoder_top: bit-serial jpeg huffman decoder, input and result registers
// depends on jhbd_pkg, jhbd_cam (dc and ac tables) and jhbd_dec
//
// Usage: the input channel carries one item per handshake (in_valid_i / in_stall_o).
// An item with req_type_i = 0 writes one slot of the dc or ac table (table_select_i);
// an index beyond the table depth is dropped. An item with req_type_i = 1 feeds one
// stream bit, msb first. A decoded symbol, an amplitude field, or an error comes out
// as one item on the result channel (out_valid_o / out_stall_i).
// Each item taken is decoded from the input register; its result is captured in the
// result register. Throughput: one item per cycle while no stalled result blocks it; the
// code match compares every active-table slot in parallel: one stream bit per cycle.
// Reset: all table slots read as empty, the decoder waits for a dc code, no result.
// A stalled result holds; the input register still takes an item while the result
// register waits, and stalls only when it holds an item whose result has no room.
// Loads and bits that give no result are never held up by a stalled output.
module jpeg_huffman_bit_decoder_top import jhbd_pkg::*; #(
  parameter int unsigned DC_ENTRIES   = DC_ENTRIES_DEF,
  parameter int unsigned AC_ENTRIES   = AC_ENTRIES_DEF,
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic              code_bit_i,
  input  logic              table_select_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [CODE_W-1:0] entry_code_i,
  input  logic [LEN_W-1:0]  entry_length_i,
  input  logic [SYM_W-1:0]  entry_symbol_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SYM_W-1:0]  symbol_o,
  output logic [CODE_W-1:0] amplitude_bits_o,
  output logic [LEN_W-1:0]  amplitude_length_o,
  output logic              is_dc_o,
  output logic              end_of_block_o,
  output logic              code_error_o
);

  logic              s1_valid_q, s1_valid_d;
  logic              s1_req_q;
  logic              s1_bit_q;
  logic              s1_tab_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [CODE_W-1:0] s1_code_q;
  logic [LEN_W-1:0]  s1_len_q;
  logic [SYM_W-1:0]  s1_sym_q;

  logic              out_valid_q, out_valid_d;
  dec_res_t          out_q;

  logic              accept;
  logic              out_free;
  logic              s1_adv;
  logic              s1_item;
  logic              res_fire;
  cam_load_t         dc_load, ac_load;
  cam_key_t          key;
  cam_hit_t          dc_res, ac_res;
  dec_res_t          res;

  assign s1_item  = s1_valid_q && (s1_req_q == REQ_BIT);
  assign res_fire = res.valid;
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv   = !res_fire || out_free;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    dc_load.we    = s1_valid_q && s1_adv && (s1_req_q == REQ_LOAD) && (s1_tab_q == TABLE_DC);
    dc_load.index = s1_idx_q;
    dc_load.code  = s1_code_q;
    dc_load.len   = s1_len_q;
    dc_load.sym   = s1_sym_q;
    ac_load       = dc_load;
    ac_load.we    = s1_valid_q && s1_adv && (s1_req_q == REQ_LOAD) && (s1_tab_q == TABLE_AC);
  end

  jhbd_cam #(.DEPTH(DC_ENTRIES)) u_dc_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (dc_load),
    .key_i  (key),
    .res_o  (dc_res)
  );

  jhbd_cam #(.DEPTH(AC_ENTRIES)) u_ac_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ac_load),
    .key_i  (key),
    .res_o  (ac_res)
  );

  jhbd_dec #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (s1_item),
    .commit_i (s1_item && s1_adv),
    .bit_i    (s1_bit_q),
    .dc_res_i (dc_res),
    .ac_res_i (ac_res),
    .key_o    (key),
    .res_o    (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_fire && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q  <= req_type_i;
      s1_bit_q  <= code_bit_i;
      s1_tab_q  <= table_select_i;
      s1_idx_q  <= entry_index_i;
      s1_code_q <= entry_code_i;
      s1_len_q  <= entry_length_i;
      s1_sym_q  <= entry_symbol_i;
    end
    if (res_fire && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign symbol_o           = out_q.symbol;
  assign amplitude_bits_o   = out_q.amp_bits;
  assign amplitude_length_o = out_q.amp_len;
  assign is_dc_o            = out_q.is_dc;
  assign end_of_block_o     = out_q.eob;
  assign code_error_o       = out_q.err;

endmodule

>>> rtl/jhbd_checker.sv
// jhbd_checker: port-level checks on the result channel of the decoder, and its bind
// depends on jhbd_pkg; attaches to jpeg_huffman_bit_decoder_top
module jhbd_checker import jhbd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [SYM_W-1:0]  symbol_o,
  input logic [CODE_W-1:0] amplitude_bits_o,
  input logic [LEN_W-1:0]  amplitude_length_o,
  input logic              is_dc_o,
  input logic              end_of_block_o,
  input logic              code_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o)
      && $stable(amplitude_bits_o) && $stable(code_error_o))
    else $error("result item changed while stalled");

  a_eob_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_block_o |-> symbol_o == '0 && !code_error_o)
    else $error("end of block on a nonzero or failed symbol");

  a_ac_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_error_o && !is_dc_o |-> symbol_o == '0
      && amplitude_length_o == '0 && amplitude_bits_o == '0)
    else $error("ac error item carries data");

  a_amp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !code_error_o |->
      (is_dc_o && amplitude_length_o == symbol_o[LEN_W-1:0] && symbol_o <= DC_CAT_MAX)
      || (!is_dc_o && amplitude_length_o == {1'b0, symbol_o[3:0]}))
    else $error("amplitude length does not follow the symbol");

endmodule

bind jpeg_huffman_bit_decoder_top jhbd_checker u_jhbd_checker (.*);

>>> bench/tb.sv
// tb: self-checking bench for jpeg_huffman_bit_decoder_top, built on jhbd_pkg
// loads random prefix-code tables, streams well-formed and broken code bits with random
// gaps and output stalls, and checks every decoded symbol against a tracked decoder state
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jhbd_pkg::*;

  localparam int DC_DEPTH    = DC_ENTRIES_DEF;
  localparam int AC_DEPTH    = AC_ENTRIES_DEF;
  localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
  localparam int ITEM_TARGET = 1600;
  localparam int IDLE_LIMIT  = 2000;
  localparam int REPORT_MAX  = 50;

  typedef struct packed {
    logic              req;
    logic              bit_val;
    logic              tsel;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic [SYM_W-1:0]  sym;
  } dec_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] amp_bits;
    logic [LEN_W-1:0]  amp_len;
    logic              is_dc;
    logic              eob;
    logic              err;
  } sym_result_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic [SYM_W-1:0]  sym;
  } huff_entry_t;

  class huff_symbol_board;
    logic [CODE_W-1:0] dc_code [DC_DEPTH];
    logic [LEN_W-1:0]  dc_len  [DC_DEPTH];
    logic [SYM_W-1:0]  dc_sym  [DC_DEPTH];
    logic [CODE_W-1:0] ac_code [AC_DEPTH];
    logic [LEN_W-1:0]  ac_len  [AC_DEPTH];
    logic [SYM_W-1:0]  ac_sym  [AC_DEPTH];
    bit                want_dc;
    bit                collecting;
    logic [CODE_W-1:0] prefix;
    int unsigned       plen;
    logic [CODE_W-1:0] amp_acc;
    int unsigned       amp_left;
    int unsigned       amp_total;
    logic [SYM_W-1:0]  held_sym;
    sym_result_t       due_symbols[$];
    int unsigned       mismatches;

    function new();
      want_dc    = 1'b1;
      collecting = 1'b0;
      prefix     = '0;
      plen       = 0;
      amp_acc    = '0;
      amp_left   = 0;
      amp_total  = 0;
      held_sym   = '0;
      mismatches = 0;
      foreach (dc_len[k]) begin
        dc_len[k]  = '0;
        dc_code[k] = '0;
        dc_sym[k]  = '0;
      end
      foreach (ac_len[k]) begin
        ac_len[k]  = '0;
        ac_code[k] = '0;
        ac_sym[k]  = '0;
      end
    endfunction

    function int find_slot(bit dc_side);
      int                depth;
      logic [31:0]       mask;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
      depth = dc_side ? DC_DEPTH : AC_DEPTH;
      mask  = (32'd1 << plen) - 32'd1;
      for (int k = 0; k < depth; k++) begin
        if (dc_side) begin
          len  = dc_len[k];
          code = dc_code[k];
        end else begin
          len  = ac_len[k];
          code = ac_code[k];
        end
        if (len != '0 && 32'(len) == plen && (32'(code) & mask) == 32'(prefix)) begin
          return k;
        end
      end
      return -1;
    endfunction

    function void close_symbol(logic [SYM_W-1:0] s, logic [CODE_W-1:0] bits, int unsigned n);
      sym_result_t r;
      r.symbol   = s;
      r.amp_bits = bits;
      r.amp_len  = LEN_W'(n);
      r.is_dc    = want_dc;
      r.eob      = (s == '0);
      r.err      = 1'b0;
      due_symbols.push_back(r);
      want_dc = r.eob;
    endfunction

    function void flag_error(logic [SYM_W-1:0] s);
      sym_result_t r;
      r        = '0;
      r.symbol = s;
      r.is_dc  = want_dc;
      r.err    = 1'b1;
      due_symbols.push_back(r);
      want_dc = 1'b1;
    endfunction

    function void take_item(dec_item_t it);
      int               slot;
      int unsigned      need;
      logic [SYM_W-1:0] s;
      if (it.req == REQ_LOAD) begin
        if (it.tsel == TABLE_DC) begin
          if (int'(it.index) < DC_DEPTH) begin
            dc_code[it.index] = it.code;
            dc_len[it.index]  = it.length;
            dc_sym[it.index]  = it.sym;
          end
        end else if (int'(it.index) < AC_DEPTH) begin
          ac_code[it.index] = it.code;
          ac_len[it.index]  = it.length;
          ac_sym[it.index]  = it.sym;
        end
        return;
      end
      if (collecting) begin
        amp_acc = {amp_acc[CODE_W-2:0], it.bit_val};
        if (amp_left > 0) begin
          amp_left--;
        end
        if (amp_left == 0) begin
          collecting = 1'b0;
          close_symbol(held_sym, amp_acc, amp_total);
        end
        return;
      end
      prefix = {prefix[CODE_W-2:0], it.bit_val};
      if (plen < CODE_W) begin
        plen++;
      end
      slot = find_slot(want_dc);
      if (slot < 0) begin
        if (plen >= MAX_LEN) begin
          flag_error('0);
          prefix = '0;
          plen   = 0;
        end
        return;
      end
      prefix = '0;
      plen   = 0;
      if (want_dc) begin
        s = dc_sym[slot];
        if (s > DC_CAT_MAX) begin
          flag_error(s);
          return;
        end
        need = 32'(s);
      end else begin
        s    = ac_sym[slot];
        need = 32'(s & NIBBLE_MASK);
      end
      if (need == 0) begin
        close_symbol(s, '0, 0);
      end else begin
        collecting = 1'b1;
        held_sym   = s;
        amp_acc    = '0;
        amp_left   = need;
        amp_total  = need;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_symbol(sym_result_t got);
      sym_result_t want;
      if (due_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result expected none actual symbol %0h error %0b",
                   $time, got.symbol, got.err);
        end
        return;
      end
      want = due_symbols.pop_front();
      compare_field("symbol", 32'(want.symbol), 32'(got.symbol));
      compare_field("amplitude_bits", 32'(want.amp_bits), 32'(got.amp_bits));
      compare_field("amplitude_length", 32'(want.amp_len), 32'(got.amp_len));
      compare_field("is_dc", 32'(want.is_dc), 32'(got.is_dc));
      compare_field("end_of_block", 32'(want.eob), 32'(got.eob));
      compare_field("code_error", 32'(want.err), 32'(got.err));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              req_type_i;
  logic              code_bit_i;
  logic              table_select_i;
  logic [IDX_W-1:0]  entry_index_i;
  logic [CODE_W-1:0] entry_code_i;
  logic [LEN_W-1:0]  entry_length_i;
  logic [SYM_W-1:0]  entry_symbol_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SYM_W-1:0]  symbol_o;
  logic [CODE_W-1:0] amplitude_bits_o;
  logic [LEN_W-1:0]  amplitude_length_o;
  logic              is_dc_o;
  logic              end_of_block_o;
  logic              code_error_o;

  huff_symbol_board board;
  int unsigned      items_taken = 0;
  int unsigned      idle_cycles = 0;
  int               ac_used     = 2;
  bit               no_gap      = 1'b0;

  jpeg_huffman_bit_decoder_top i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic dec_item_t make_load(logic tsel, logic [IDX_W-1:0] idx,
                                          logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                                          logic [SYM_W-1:0] sym);
    dec_item_t it;
    it.req     = REQ_LOAD;
    it.bit_val = 1'($urandom);
    it.tsel    = tsel;
    it.index   = idx;
    it.code    = code;
    it.length  = len;
    it.sym     = sym;
    return it;
  endfunction

  function automatic dec_item_t make_bit(logic b);
    dec_item_t it;
    it.req     = REQ_BIT;
    it.bit_val = b;
    it.tsel    = 1'($urandom);
    it.index   = IDX_W'($urandom);
    it.code    = CODE_W'($urandom);
    it.length  = LEN_W'($urandom);
    it.sym     = SYM_W'($urandom);
    return it;
  endfunction

  function automatic huff_entry_t junk_entry();
    huff_entry_t e;
    e.code   = CODE_W'($urandom);
    e.sym    = SYM_W'($urandom);
    e.length = ($urandom_range(0, 1) == 0) ? '0 : LEN_W'($urandom_range(17, 31));
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_max_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return MAX_LEN;
    if (r < 25) return $urandom_range(10, 15);
    return $urandom_range(1, 8);
  endfunction

  // canonical prefix code with random length counts, upper code bits filled with noise
  function automatic void build_code(input logic [SYM_W-1:0] syms[$], input int max_len,
                                     output huff_entry_t tab[$]);
    int                left;
    int                avail;
    int                hi;
    int                take;
    logic [CODE_W-1:0] next;
    huff_entry_t       e;
    tab   = {};
    left  = syms.size();
    avail = 1;
    next  = '0;
    for (int len = 1; len <= max_len && left > 0; len++) begin
      avail = avail * 2;
      if (len > 1) begin
        next = next << 1;
      end
      hi = (left < avail) ? left : avail;
      if (len < max_len && hi == avail) begin
        hi = avail - 1;
      end
      take = (len == max_len) ? hi : int'($urandom_range(0, hi));
      for (int k = 0; k < take; k++) begin
        e.length = LEN_W'(len);
        e.sym    = syms[syms.size() - left];
        e.code   = (CODE_W'($urandom) << len) | next;
        tab.push_back(e);
        next++;
        left--;
      end
      avail -= take;
    end
  endfunction

  task automatic send_item(input dec_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    req_type_i     <= it.req;
    code_bit_i     <= it.bit_val;
    table_select_i <= it.tsel;
    entry_index_i  <= it.index;
    entry_code_i   <= it.code;
    entry_length_i <= it.length;
    entry_symbol_i <= it.sym;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_item(it);
    items_taken++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.due_symbols.size() != 0) @(posedge clk_i);
  endtask

  task automatic resync();
    while (board.collecting || board.plen != 0) send_item(make_bit(1'($urandom)));
  endtask

  task automatic send_symbol(input huff_entry_t e);
    int need;
    if (board.want_dc) begin
      need = (e.sym <= DC_CAT_MAX) ? int'(e.sym) : 0;
    end else begin
      need = int'(e.sym & NIBBLE_MASK);
    end
    for (int b = int'(e.length) - 1; b >= 0; b--) send_item(make_bit(e.code[b]));
    repeat (need) send_item(make_bit(1'($urandom)));
  endtask

  task automatic load_tables(input huff_entry_t dc_tab[$], input huff_entry_t ac_tab[$]);
    huff_entry_t e;
    for (int k = 0; k < DC_DEPTH; k++) begin
      e = (k < dc_tab.size()) ? dc_tab[k] : junk_entry();
      send_item(make_load(TABLE_DC, IDX_W'(k), e.code, e.length, e.sym));
    end
    foreach (ac_tab[k]) begin
      send_item(make_load(TABLE_AC, IDX_W'(k), ac_tab[k].code, ac_tab[k].length,
                          ac_tab[k].sym));
    end
    for (int k = ac_tab.size(); k < ac_used; k++) begin
      e = junk_entry();
      send_item(make_load(TABLE_AC, IDX_W'(k), e.code, e.length, e.sym));
    end
    ac_used = ac_tab.size();
    // shadowed copy of a live code at a higher slot
    if ($urandom_range(0, 2) == 0) begin
      e     = ac_tab[$urandom_range(0, ac_tab.size() - 1)];
      e.sym = SYM_W'($urandom);
      send_item(make_load(TABLE_AC, IDX_W'(ac_used), e.code, e.length, e.sym));
      ac_used++;
    end
  endtask

  task automatic run_phase();
    huff_entry_t      dc_tab[$];
    huff_entry_t      ac_tab[$];
    logic [SYM_W-1:0] syms[$];
    huff_entry_t      e;
    int               r;
    no_gap = ($urandom_range(0, 9) < 3);
    repeat ($urandom_range(1, DC_DEPTH)) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        syms.push_back(SYM_W'($urandom_range(17, 255)));
      end else if (r < 12) begin
        syms.push_back(DC_CAT_MAX);
      end else begin
        syms.push_back(SYM_W'($urandom_range(0, 11)));
      end
    end
    build_code(syms, pick_max_len(), dc_tab);
    syms = {};
    syms.push_back(8'h00);
    syms.push_back(8'hF0);
    repeat ($urandom_range(0, 38)) syms.push_back(SYM_W'($urandom));
    build_code(syms, pick_max_len(), ac_tab);
    load_tables(dc_tab, ac_tab);
    repeat ($urandom_range(15, 40)) begin
      if (items_taken >= ITEM_TARGET) break;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 20)) send_item(make_bit(1'($urandom)));
      end else if (r < 13) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(make_load(1'($urandom), IDX_W'($urandom), CODE_W'($urandom),
                              LEN_W'($urandom), SYM_W'($urandom)));
        end
      end
      resync();
      if (board.want_dc) begin
        e = dc_tab[$urandom_range(0, dc_tab.size() - 1)];
      end else if ($urandom_range(0, 99) < 15) begin
        e = ac_tab[0];
      end else begin
        e = ac_tab[$urandom_range(0, ac_tab.size() - 1)];
      end
      send_symbol(e);
    end
    if ($urandom_range(0, 2) == 0) begin
      drain();
    end
  endtask

  initial begin
    logic [12:0] dir_bits;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_LOAD;
    code_bit_i     = 1'b0;
    table_select_i = TABLE_DC;
    entry_index_i  = '0;
    entry_code_i   = '0;
    entry_length_i = '0;
    entry_symbol_i = '0;
    board          = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // dc: 0 -> eob, 10 -> category too large, 11 -> category 2 (slot 15 shadowed)
    send_item(make_load(TABLE_DC, 8'd0, 16'hFFFE, 5'd1, 8'h00));
    send_item(make_load(TABLE_DC, 8'd1, 16'hAAA2, 5'd2, 8'hFF));
    send_item(make_load(TABLE_DC, 8'd2, 16'h0003, 5'd2, 8'h02));
    send_item(make_load(TABLE_DC, 8'd3, 16'hFFFF, 5'd31, 8'h55));
    send_item(make_load(TABLE_DC, 8'd15, 16'hFFF3, 5'd2, 8'h05));
    send_item(make_load(TABLE_DC, 8'd16, 16'h0000, 5'd1, 8'h09));
    send_item(make_load(TABLE_DC, 8'd255, 16'hFFFF, 5'd16, 8'hFF));
    // ac: 0 -> eob, 10 -> zrl, 11 -> run 3 size 1
    send_item(make_load(TABLE_AC, 8'd0, 16'h0000, 5'd1, 8'h00));
    send_item(make_load(TABLE_AC, 8'd1, 16'h0002, 5'd2, 8'hF0));
    send_item(make_load(TABLE_AC, 8'd255, 16'h0003, 5'd2, 8'h31));
    dir_bits = 13'b0101110101110;
    for (int b = 12; b >= 0; b--) send_item(make_bit(dir_bits[b]));
    drain();

    while (items_taken < ITEM_TARGET) run_phase();
    drain();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(20, 150)) begin
            @(negedge clk_i);
            out_stall_i <= 1'b0;
          end
        end
        9: begin
          repeat ($urandom_range(10, 50)) begin
            @(negedge clk_i);
            out_stall_i <= 1'b1;
          end
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            @(negedge clk_i);
            out_stall_i <= 1'b1;
          end
          repeat ($urandom_range(1, 6)) begin
            @(negedge clk_i);
            out_stall_i <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_symbol('{symbol_o, amplitude_bits_o, amplitude_length_o, is_dc_o,
                           end_of_block_o, code_error_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
